FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies another in the same cycle
`define ASSERT_SAME_CYCLE(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed: same cycle implication");

// condition implies another in the following cycle
`define ASSERT_NEXT_CYCLE(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed: next cycle implication");

`endif

FILE: rtl/core/tbuuid_pkg.sv
// ----------------------------------------------------------------------------
// tbuuid_pkg
// widths, constants and shared types of the time based uuid generator
// ----------------------------------------------------------------------------
`default_nettype none

package tbuuid_pkg;

   // field widths
   localparam int SEC_W   = 36;
   localparam int USEC_W  = 20;
   localparam int NODE_W  = 48;
   localparam int SEQ_W   = 14;
   localparam int ADJ_W   = 4;
   localparam int STAMP_W = 60;
   localparam int LOW_W   = 24;
   localparam int TICK_W  = 24;

   // packed stream widths
   localparam int REQ_DATA_W = SEC_W + USEC_W + NODE_W;
   localparam int RSP_DATA_W = 32 + 16 + 16 + 16 + NODE_W;

   // timestamp constants
   localparam logic [TICK_W-1:0]  TICKS_PER_SECOND = 24'd10000000;
   localparam logic [STAMP_W-1:0] EPOCH_OFFSET     = 60'h01B21DD213814000;
   localparam logic [ADJ_W-1:0]   ADJUST_LIMIT     = 4'd10;
   localparam logic [3:0]         VERSION_NIBBLE   = 4'h1;
   localparam logic [1:0]         VARIANT_BITS     = 2'b10;

   // decision handed from the clock state tracker to the pipeline
   typedef struct packed {
      logic             emit;
      logic [ADJ_W-1:0] adj;
      logic [SEQ_W-1:0] seq;
   } tick_info_type;

endpackage

`default_nettype wire

FILE: rtl/core/tbuuid_clock_state.sv
// ----------------------------------------------------------------------------
// tbuuid_clock_state
// last sample, clock sequence and tick adjustment with the per request decision
// ----------------------------------------------------------------------------
`default_nettype none

module tbuuid_clock_state (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [tbuuid_pkg::SEC_W-1:0]  sec,
   input  wire logic [tbuuid_pkg::USEC_W-1:0] usec,
   output tbuuid_pkg::tick_info_type          info
);
   import tbuuid_pkg::*;

   logic [SEC_W-1:0]  last_sec_ff;
   logic [USEC_W-1:0] last_usec_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [ADJ_W-1:0]  adj_ff;

   logic [SEC_W-1:0]  last_sec_in;
   logic [USEC_W-1:0] last_usec_in;
   logic [SEQ_W-1:0]  seq_in;
   logic [ADJ_W-1:0]  adj_in;
   logic              emit;
   logic              same_sec;
   logic              earlier;
   logic              same_time;

   // compare the sample with the stored one, seconds first
   assign same_sec  = (sec == last_sec_ff);
   assign earlier   = (sec < last_sec_ff) || (same_sec && (usec < last_usec_ff));
   assign same_time = same_sec && (usec == last_usec_ff);

   // next state and result decision
   always_comb begin
      last_sec_in  = last_sec_ff;
      last_usec_in = last_usec_ff;
      seq_in       = seq_ff;
      adj_in       = adj_ff;
      emit         = 1'b1;
      if (earlier) begin
         seq_in       = seq_ff + SEQ_W'(1);
         adj_in       = '0;
         last_sec_in  = sec;
         last_usec_in = usec;
      end else if (same_time) begin
         if (adj_ff >= ADJUST_LIMIT) begin
            emit = 1'b0;
         end else begin
            adj_in = adj_ff + ADJ_W'(1);
         end
      end else begin
         adj_in       = '0;
         last_sec_in  = sec;
         last_usec_in = usec;
      end
   end

   assign info.emit = emit;
   assign info.adj  = adj_in;
   assign info.seq  = seq_in;

   // state update on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sec_ff  <= '0;
         last_usec_ff <= '0;
         seq_ff       <= '0;
         adj_ff       <= '0;
      end else if (step) begin
         last_sec_ff  <= last_sec_in;
         last_usec_ff <= last_usec_in;
         seq_ff       <= seq_in;
         adj_ff       <= adj_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tbuuid_stamp.sv
// ----------------------------------------------------------------------------
// tbuuid_stamp
// 100 ns gregorian timestamp: registered products, then one final sum
// ----------------------------------------------------------------------------
`default_nettype none

module tbuuid_stamp (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [tbuuid_pkg::SEC_W-1:0]  sec,
   input  wire logic [tbuuid_pkg::USEC_W-1:0] usec,
   input  wire logic [tbuuid_pkg::ADJ_W-1:0]  adj,
   output      logic [tbuuid_pkg::STAMP_W-1:0] stamp
);
   import tbuuid_pkg::*;

   logic [STAMP_W-1:0] sec_ticks_ff;
   logic [LOW_W-1:0]   low_ticks_ff;
   logic [STAMP_W-1:0] sec_ticks_in;
   logic [LOW_W-1:0]   low_ticks_in;
   logic [LOW_W-1:0]   usec_ext;

   // seconds times ten million, and microseconds times ten plus adjustment
   assign usec_ext     = LOW_W'(usec);
   assign sec_ticks_in = STAMP_W'(sec) * STAMP_W'(TICKS_PER_SECOND);
   assign low_ticks_in = (usec_ext << 3) + (usec_ext << 1) + LOW_W'(adj);

   always_ff @(posedge clock) begin
      if (load) begin
         sec_ticks_ff <= sec_ticks_in;
         low_ticks_ff <= low_ticks_in;
      end
   end

   // epoch offset to 15 oct 1582
   assign stamp = sec_ticks_ff + STAMP_W'(low_ticks_ff) + EPOCH_OFFSET;

endmodule

`default_nettype wire

FILE: rtl/core/time_based_uuid_generator_core.sv
// ----------------------------------------------------------------------------
// time_based_uuid_generator_core
// version 1 uuid fields from a wall clock sample and random node bits
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_tvalid/tready    | seconds, microseconds, random_node
//  rsp_     | out       | rsp_tvalid/tready    | time low/mid/high, sequence, node
//
//  one transaction per cycle sustained while rsp_tready stays high; a request
//  moves through the input register, product register and result register
//  a request that repeats the same time after ten adjustments gives no result
//  rsp_tready low stalls the result register; bubbles ahead of it still fill
//  synchronous reset clears all valid flags, stored sample and clock sequence
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module time_based_uuid_generator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // seconds[35:0], microseconds[55:36], random_node[103:56]
   input  wire logic [tbuuid_pkg::REQ_DATA_W-1:0]   req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // time_low_field[31:0], time_mid_field[47:32], time_high_version[63:48],
   // sequence_and_variant[79:64], node_field[127:80]
   output      logic [tbuuid_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tbuuid_pkg::*;

   // input register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [SEC_W-1:0]  s1_sec_ff;
   logic [USEC_W-1:0] s1_usec_ff;
   logic [NODE_W-1:0] s1_node_ff;

   // product register
   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic [SEQ_W-1:0]  s2_seq_ff;
   logic [NODE_W-1:0] s2_node_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic               s1_ready;
   logic               s2_ready;
   logic               s3_ready;
   logic               s1_fire;
   logic               req_fire;
   tick_info_type      info;
   logic [STAMP_W-1:0] stamp;

   // stage ready chain, each stage moves when the next one frees up
   assign s3_ready = !rsp_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s1_fire  = s1_valid_ff && s2_ready;
   assign req_fire = req_tvalid && s1_ready;

   assign req_tready = s1_ready;

   // input register
   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_sec_ff  <= req_tdata[SEC_W-1:0];
         s1_usec_ff <= req_tdata[SEC_W+USEC_W-1:SEC_W];
         s1_node_ff <= req_tdata[REQ_DATA_W-1:SEC_W+USEC_W];
      end
   end

   // clock sequence and tick adjustment tracking
   tbuuid_clock_state u_clock_state (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .sec   (s1_sec_ff),
      .usec  (s1_usec_ff),
      .info  (info)
   );

   // timestamp products and final sum
   tbuuid_stamp u_stamp (
      .clock (clock),
      .load  (s2_ready),
      .sec   (s1_sec_ff),
      .usec  (s1_usec_ff),
      .adj   (info.adj),
      .stamp (stamp)
   );

   // product register, dropped requests leave a bubble
   assign s2_valid_in = s2_ready ? (s1_valid_ff && info.emit) : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_ready) begin
         s2_seq_ff  <= info.seq;
         s2_node_ff <= s1_node_ff;
      end
   end

   // uuid field assembly
   assign rsp_data_in = {s2_node_ff,
                         VARIANT_BITS, s2_seq_ff,
                         VERSION_NIBBLE, stamp[59:48],
                         stamp[47:32],
                         stamp[31:0]};
   assign rsp_valid_in = s3_ready ? s2_valid_ff : rsp_valid_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s3_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // adjustment never passes its limit on an emitted transaction
   `ASSERT_SAME_CYCLE(a_adj_limit, s1_fire && info.emit, info.adj <= ADJUST_LIMIT)
   // a request without result leaves no transaction in the product stage
   `ASSERT_NEXT_CYCLE(a_drop_bubble, s1_fire && !info.emit, !s2_valid_ff)
   // a blocked product stage keeps its transaction
   `ASSERT_NEXT_CYCLE(a_s2_hold, s2_valid_ff && !s3_ready, s2_valid_ff)

endmodule

`default_nettype wire

FILE: verif/time_based_uuid_generator_core_test.sv
// ----------------------------------------------------------------------------
// time_based_uuid_generator_core_test
// self-checking bench for the version 1 uuid generator: a queue-fed driver
// offers clock samples, a monitor predicts each uuid from its own copy of the
// clock state and checks every result transaction field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module time_based_uuid_generator_core_test;

   import tbuuid_pkg::*;

   // request payload, first member in the top bits
   typedef struct packed {
      logic [NODE_W-1:0] random_node;
      logic [USEC_W-1:0] microseconds;
      logic [SEC_W-1:0]  seconds;
   } clock_sample_type;

   // result payload, first member in the top bits
   typedef struct packed {
      logic [NODE_W-1:0] node_field;
      logic [15:0]       sequence_and_variant;
      logic [15:0]       time_high_version;
      logic [15:0]       time_mid_field;
      logic [31:0]       time_low_field;
   } uuid_fields_type;

   localparam int CALM_TAIL  = 60;
   localparam int HOLD_START = 150;
   localparam int HOLD_LEN   = 250;
   localparam int MAX_USEC   = 999999;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // seconds[35:0], microseconds[55:36], random_node[103:56]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // time_low_field[31:0], time_mid_field[47:32], time_high_version[63:48],
   // sequence_and_variant[79:64], node_field[127:80]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   clock_sample_type sample_queue[$];
   uuid_fields_type  pending_uuids[$];

   // predicted clock state
   logic [SEC_W-1:0]  seen_seconds;
   logic [USEC_W-1:0] seen_micros;
   logic [SEQ_W-1:0]  seq_count;
   logic [ADJ_W-1:0]  tick_adj;

   int   mismatch_count = 0;
   int   accepted_count = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   logic hold_rsp = 1'b0;

   uuid_fields_type next_uuid;
   uuid_fields_type got_uuid;
   uuid_fields_type want_uuid;

   time_based_uuid_generator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // one line per mismatch
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // advance the clock state for one sample; returns 0 when the adjustment
   // is exhausted and the request yields nothing
   function automatic bit issue_uuid(input clock_sample_type s,
                                     output uuid_fields_type u);
      logic [63:0] stamp;
      u = '0;
      if (s.seconds < seen_seconds ||
          (s.seconds == seen_seconds && s.microseconds < seen_micros)) begin
         seq_count    = seq_count + 1'b1;
         tick_adj     = '0;
         seen_seconds = s.seconds;
         seen_micros  = s.microseconds;
      end else if (s.seconds == seen_seconds && s.microseconds == seen_micros) begin
         if (tick_adj >= ADJUST_LIMIT)
            return 1'b0;
         tick_adj = tick_adj + 1'b1;
      end else begin
         tick_adj     = '0;
         seen_seconds = s.seconds;
         seen_micros  = s.microseconds;
      end
      stamp = 64'(s.microseconds) * 64'd10 + 64'(tick_adj)
            + 64'(s.seconds) * 64'(TICKS_PER_SECOND) + 64'(EPOCH_OFFSET);
      u.time_low_field       = stamp[31:0];
      u.time_mid_field       = stamp[47:32];
      u.time_high_version    = {VERSION_NIBBLE, stamp[59:48]};
      u.sequence_and_variant = {VARIANT_BITS, seq_count};
      u.node_field           = s.random_node;
      return 1'b1;
   endfunction

   function automatic logic [NODE_W-1:0] rand_node();
      return NODE_W'({$urandom, $urandom});
   endfunction

   task automatic push_sample(input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec,
                              input logic [NODE_W-1:0] node);
      clock_sample_type s;
      s.seconds      = sec;
      s.microseconds = usec;
      s.random_node  = node;
      sample_queue.push_back(s);
   endtask

   // request driver: takes the next sample once the current one is taken, with random idle gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            if (!hold_rsp && sample_queue.size() > CALM_TAIL &&
                $urandom_range(0, 5) == 0) begin
               req_gap    <= $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= sample_queue.pop_front();
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: random stall bursts plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (sample_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
         rsp_gap    <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long receiver hold so the pipeline fills and backs up the input
   initial begin
      while (accepted_count < HOLD_START)
         @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // monitor: predict on each request transaction, check each result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted_count++;
            if (issue_uuid(clock_sample_type'(req_tdata), next_uuid))
               pending_uuids.push_back(next_uuid);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_uuid = uuid_fields_type'(rsp_tdata);
            if (pending_uuids.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[63:0], 64'd0);
            end else begin
               want_uuid = pending_uuids.pop_front();
               if (got_uuid.time_low_field !== want_uuid.time_low_field)
                  report_mismatch("time_low_field", got_uuid.time_low_field,
                                  want_uuid.time_low_field);
               if (got_uuid.time_mid_field !== want_uuid.time_mid_field)
                  report_mismatch("time_mid_field", got_uuid.time_mid_field,
                                  want_uuid.time_mid_field);
               if (got_uuid.time_high_version !== want_uuid.time_high_version)
                  report_mismatch("time_high_version", got_uuid.time_high_version,
                                  want_uuid.time_high_version);
               if (got_uuid.sequence_and_variant !== want_uuid.sequence_and_variant)
                  report_mismatch("sequence_and_variant", got_uuid.sequence_and_variant,
                                  want_uuid.sequence_and_variant);
               if (got_uuid.node_field !== want_uuid.node_field)
                  report_mismatch("node_field", got_uuid.node_field,
                                  want_uuid.node_field);
            end
         end
      end
   end

   // run limit
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus and end of run
   initial begin
      logic [SEC_W-1:0]  cur_sec;
      logic [USEC_W-1:0] cur_usec;
      int                made;
      int                pick;
      int                step;
      int                runs;

      seen_seconds = '0;
      seen_micros  = '0;
      seq_count    = '0;
      tick_adj     = '0;

      // same time as the reset state: adjustment climbs to its limit, then drops
      for (int i = 0; i < 12; i++)
         push_sample('0, '0, (i % 2 == 0) ? '0 : '1);
      // later time at the top of the microsecond range, then beyond it
      push_sample(36'd1, 20'd999999, '1);
      push_sample(36'd1, '1, 48'hAAAA_AAAA_AAAA);
      // time went backwards on microseconds, then on seconds
      push_sample(36'd1, 20'd5, 48'h5555_5555_5555);
      push_sample('0, '1, rand_node());
      // largest sample, repeated once
      push_sample('1, '1, '1);
      push_sample('1, '1, '0);
      // back to zero, then single high bits, then the values just below them
      push_sample('0, '0, rand_node());
      push_sample(36'h8_0000_0000, 20'h80000, 48'h8000_0000_0000);
      push_sample(36'h8_0000_0000, 20'h80000, 48'h0000_0000_0001);
      push_sample(36'h7_FFFF_FFFF, 20'h7FFFF, rand_node());

      // random part: mostly monotonic time with repeat runs, rewinds, random jumps and noise
      cur_sec  = 36'd1_700_000_000;
      cur_usec = '0;
      made     = 0;
      while (made < 550) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            step = $urandom_range(1, 2000);
            if (32'(cur_usec) + step > MAX_USEC) begin
               cur_sec  = cur_sec + 1'b1;
               cur_usec = USEC_W'(32'(cur_usec) + step - 1000000);
            end else begin
               cur_usec = cur_usec + USEC_W'(step);
            end
            push_sample(cur_sec, cur_usec, rand_node());
            made++;
         end else if (pick < 70) begin
            runs = $urandom_range(1, 12);
            for (int i = 0; i < runs; i++)
               push_sample(cur_sec, cur_usec, rand_node());
            made += runs;
         end else if (pick < 82) begin
            if ($urandom_range(0, 1) == 0 && cur_usec > 0)
               cur_usec = cur_usec - USEC_W'($urandom_range(1, 32'(cur_usec)));
            else if (cur_sec > 0)
               cur_sec = cur_sec - 1'b1;
            push_sample(cur_sec, cur_usec, rand_node());
            made++;
         end else if (pick < 90) begin
            cur_sec  = SEC_W'({$urandom, $urandom});
            cur_usec = USEC_W'($urandom_range(0, MAX_USEC));
            push_sample(cur_sec, cur_usec, rand_node());
            made++;
         end else begin
            // noise: any seconds, any 20-bit microseconds, state untouched
            push_sample(SEC_W'({$urandom, $urandom}), USEC_W'($urandom), rand_node());
            made++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      while (pending_uuids.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_count == 0 && pending_uuids.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: time_based_uuid_generator_core.f
+incdir+rtl/core
rtl/core/tbuuid_pkg.sv
rtl/core/tbuuid_clock_state.sv
rtl/core/tbuuid_stamp.sv
rtl/core/time_based_uuid_generator_core.sv
verif/time_based_uuid_generator_core_test.sv
